// ----- rtl/int_to_decimal_ascii_assert.svh -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_assert.svh
// Assertion macros shared by the decimal text converter.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is high.
`define IDTOA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define IDTOA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IDTOA_ASSERT(lbl, clk, rst, prop, msg)
`define IDTOA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/idtoa_pkg.sv -----
// ----------------------------------------------------------------------------
// idtoa_pkg
// Types and constants shared by the decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package idtoa_pkg;

   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 6;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 6'd48;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
   localparam logic [DIGIT_W-1:0] DIGIT_ADJ = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_INC = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_EMIT
   } idtoa_state_type;

   // Command broadcast to every digit cell of the row.
   typedef struct packed {
      logic clear;
      logic bit_shift;
      logic dig_shift;
   } idtoa_cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/idtoa_bcd_cell.sv -----
// ----------------------------------------------------------------------------
// idtoa_bcd_cell
// One decimal digit of the conversion row: clear, add-3 correction and bit
// shift, or a whole-digit shift from the lower neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module idtoa_bcd_cell (
   input  wire                           clock,
   input  idtoa_pkg::idtoa_cell_ctrl_type ctrl,
   input  wire                           carry_from_low,
   input  wire [idtoa_pkg::DIGIT_W-1:0]  digit_from_low,
   output logic                          carry_to_high,
   output logic [idtoa_pkg::DIGIT_W-1:0] digit
);
   import idtoa_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adjusted;

   // A digit of five or more overflows past nine once doubled, so it is
   // corrected before the shift.
   always_comb begin
      adjusted = (digit_ff >= DIGIT_ADJ) ? (digit_ff + DIGIT_INC) : digit_ff;
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.bit_shift) begin
         digit_in = {adjusted[DIGIT_W-2:0], carry_from_low};
      end else if (ctrl.dig_shift) begin
         digit_in = digit_from_low;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_to_high = adjusted[DIGIT_W-1];
   assign digit         = digit_ff;

endmodule

`default_nettype wire

// ----- rtl/idtoa_chain.sv -----
// ----------------------------------------------------------------------------
// idtoa_chain
// Row of decimal digit cells, least significant digit at index zero.
// ----------------------------------------------------------------------------
`default_nettype none

module idtoa_chain #(
   parameter int NUM_DIGITS = 10
) (
   input  wire                           clock,
   input  idtoa_pkg::idtoa_cell_ctrl_type ctrl,
   input  wire                           serial_bit,
   output logic                          carry_out,
   output logic [idtoa_pkg::DIGIT_W-1:0] top_digit
);
   import idtoa_pkg::*;

   logic [DIGIT_W-1:0] digit_q [NUM_DIGITS];
   logic [NUM_DIGITS-1:0] carry_q;

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_low
         idtoa_bcd_cell u_cell (
            .clock          (clock),
            .ctrl           (ctrl),
            .carry_from_low (serial_bit),
            .digit_from_low ('0),
            .carry_to_high  (carry_q[i]),
            .digit          (digit_q[i])
         );
      end else begin : g_mid
         idtoa_bcd_cell u_cell (
            .clock          (clock),
            .ctrl           (ctrl),
            .carry_from_low (carry_q[i-1]),
            .digit_from_low (digit_q[i-1]),
            .carry_to_high  (carry_q[i]),
            .digit          (digit_q[i])
         );
      end
   end

   assign carry_out = carry_q[NUM_DIGITS-1];
   assign top_digit = digit_q[NUM_DIGITS-1];

endmodule

`default_nettype wire

// ----- rtl/int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: one request is converted by VALUE_BITS-1 shifts
// through the digit cells, then leading zeros are dropped one per cycle.
// Digits are then offered most significant first. A new request is taken
// only in idle, once the last digit of the previous one has been accepted,
// so consumer stalls also hold off further requests.
// Synchronous reset returns the controller to idle; the cells clear on load.
// ----------------------------------------------------------------------------
`default_nettype none

`include "int_to_decimal_ascii_assert.svh"

module int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire signed [VALUE_BITS-1:0]  req_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [idtoa_pkg::CHAR_W-1:0] rsp_char_code,
   output logic                         rsp_last
);
   import idtoa_pkg::*;

   localparam int MAG_BITS   = VALUE_BITS - 1;
   localparam int NUM_DIGITS = (MAG_BITS * 30103) / 100000 + 1;
   localparam int CNT_W      = $clog2(MAG_BITS + 1);
   localparam int REM_W      = $clog2(NUM_DIGITS + 1);

   idtoa_state_type     state_ff, state_in;
   logic [MAG_BITS-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]    bits_ff, bits_in;
   logic [REM_W-1:0]    remain_ff, remain_in;

   idtoa_cell_ctrl_type cell_ctrl;
   logic                chain_carry;
   logic [DIGIT_W-1:0]  top_digit;

   idtoa_chain #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_chain (
      .clock      (clock),
      .ctrl       (cell_ctrl),
      .serial_bit (shift_ff[MAG_BITS-1]),
      .carry_out  (chain_carry),
      .top_digit  (top_digit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
      end
      shift_ff <= shift_in;
      bits_ff  <= bits_in;
   end

   always_comb begin
      state_in  = state_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      remain_in = remain_ff;
      cell_ctrl = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // Zero and negative values both convert as zero.
               shift_in        = req_value[VALUE_BITS-1] ? '0 : req_value[MAG_BITS-1:0];
               bits_in         = CNT_W'(MAG_BITS);
               cell_ctrl.clear = 1'b1;
               state_in        = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cell_ctrl.bit_shift = 1'b1;
            shift_in            = shift_ff << 1;
            bits_in             = bits_ff - CNT_W'(1);
            if (bits_ff == CNT_W'(1)) begin
               remain_in = REM_W'(NUM_DIGITS);
               state_in  = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // The lowest digit is always kept, so zero still prints.
            if (top_digit == '0 && remain_ff > REM_W'(1)) begin
               cell_ctrl.dig_shift = 1'b1;
               remain_in           = remain_ff - REM_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cell_ctrl.dig_shift = 1'b1;
               remain_in           = remain_ff - REM_W'(1);
               if (remain_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_char_code = CHAR_ZERO + CHAR_W'(top_digit);
   assign rsp_last      = (remain_ff == REM_W'(1));

   `IDTOA_ASSERT(a_no_overflow, clock, reset, cell_ctrl.bit_shift |-> !chain_carry,
                 "digit row overflowed during conversion")
   `IDTOA_ASSERT(a_digit_range, clock, reset, rsp_valid |-> (top_digit <= DIGIT_MAX),
                 "emitted digit is not decimal")
   `IDTOA_ASSERT(a_remain_live, clock, reset, rsp_valid |-> (remain_ff != '0),
                 "digit emitted with no digits left")
   `IDTOA_ASSERT(a_last_to_idle, clock, reset,
                 (rsp_valid && rsp_ready && rsp_last) |=> req_ready,
                 "controller did not return to idle after the last digit")
   `IDTOA_ASSERT_ALWAYS(a_no_direct_rsp, clock, (req_valid && req_ready) |=> !rsp_valid,
                        "response raised in the cycle after a request")

endmodule

`default_nettype wire

// ----- sim/int_to_decimal_ascii_checker.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_checker
// Watches the request and result channels of the decimal text converter.
// It predicts the digit string of every accepted request and compares each
// accepted character, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module int_to_decimal_ascii_checker #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [idtoa_pkg::CHAR_W-1:0] rsp_char_code,
   input  logic                         rsp_last,
   output int                           error_count,
   output int                           chars_pending
);
   import idtoa_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } digit_char_type;

   digit_char_type expected_chars[$];
   int             errors = 0;

   assign error_count = errors;

   // Zero and every negative value give a lone '0'; a positive value gives
   // its digits with the most significant one first.
   task automatic predict_digits(input logic signed [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] rest;
      logic [3:0]            digits[$];
      digit_char_type        next_char;
      begin
         rest = value;
         if (value <= 0) begin
            digits.push_back(4'd0);
         end else begin
            while (rest != 0) begin
               digits.push_front(4'(rest % 10));
               rest = rest / 10;
            end
         end
         foreach (digits[k]) begin
            next_char.char_code = CHAR_ZERO + CHAR_W'(digits[k]);
            next_char.last      = (k == digits.size() - 1);
            expected_chars.push_back(next_char);
         end
      end
   endtask

   task automatic note_error(input string what, input int want, input int got);
      begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: %s wrong, expected %0d, got %0d", $realtime, what, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      digit_char_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_digits(req_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: unexpected character %0d last %0d", $realtime,
                           rsp_char_code, rsp_last);
               end
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.char_code) begin
                  note_error("char_code", want.char_code, rsp_char_code);
               end
               if (rsp_last !== want.last) begin
                  note_error("last", want.last, rsp_last);
               end
            end
         end
      end
      chars_pending = expected_chars.size();
   end

endmodule

// ----- sim/int_to_decimal_ascii_tb.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_tb
// Drives signed integers into the decimal text converter, first a set of
// edge values and then random values of every digit count, while both
// channels stall at random; the checker scores every character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module int_to_decimal_ascii_tb;
   import idtoa_pkg::*;

   localparam int VALUE_BITS     = 32;
   localparam int NUM_DIRECTED   = 22;
   localparam int NUM_RANDOM     = 158;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int HOLD_START     = 1500;
   localparam int HOLD_CYCLES    = 400;
   localparam int STEADY_START   = 4000;
   localparam int STEADY_CYCLES  = 1500;
   localparam int IDLE_PERCENT   = 22;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [VALUE_BITS-1:0] req_value;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [CHAR_W-1:0]            rsp_char_code;
   logic                         rsp_last;

   int error_count;
   int chars_pending;
   int stall_cycles;
   int sink_cycle;
   bit sender_idles;
   int directed_values [0:NUM_DIRECTED-1];

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_value     = '0;
      rsp_ready     = 1'b0;
      stall_cycles  = 0;
      sink_cycle    = 0;
      sender_idles  = 1'b1;
   end

   always #6 clock = ~clock;

   int_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last     (rsp_last)
   );

   int_to_decimal_ascii_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last     (rsp_last),
      .error_count  (error_count),
      .chars_pending(chars_pending)
   );

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so the next request can follow without a gap.
   task automatic send_request(input logic signed [VALUE_BITS-1:0] value);
      begin
         while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_value <= value;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
   endtask

   // Picks a digit count first so that short and long strings are equally
   // common; the rest are negatives, tiny values and full-range words.
   function automatic logic signed [VALUE_BITS-1:0] random_value();
      int unsigned pick;
      int unsigned low_bound;
      int unsigned high_bound;
      int          ndigits;
      begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            random_value = $urandom | 32'h8000_0000;
         end else if (pick < 25) begin
            random_value = $urandom_range(9);
         end else if (pick < 75) begin
            ndigits    = $urandom_range(10, 1);
            low_bound  = 1;
            for (int k = 1; k < ndigits; k++) low_bound = low_bound * 10;
            high_bound = (ndigits == 10) ? 32'h7FFF_FFFF : low_bound * 10 - 1;
            random_value = $urandom_range(high_bound, low_bound);
         end else begin
            random_value = $urandom;
         end
      end
   endfunction

   // Result side: random back-pressure, one long hold-off while requests keep
   // coming so the block backs up, and a stretch that never stalls.
   always @(negedge clock) begin
      if (!reset) begin
         sink_cycle <= sink_cycle + 1;
         if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
         end else if (sink_cycle >= STEADY_START &&
                      sink_cycle < STEADY_START + STEADY_CYCLES) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      directed_values = '{0, -1, 1, 9, 10, 99, 100, 32'h7FFF_FFFF, 32'h8000_0000,
                          1000000000, 999999999, 1999999999, 123456789,
                          32'h5555_5555, 32'h2AAA_AAAA, 32'hAAAA_AAAA,
                          32'h8000_0001, 1000, 1010101010, 7, 2000000000, -2};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_values[k]) begin
         send_request(directed_values[k]);
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         sender_idles = !(n >= 80 && n < 120);
         send_request(random_value());
      end
      req_valid <= 1'b0;

      while (chars_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
